>>> rtl/core/tlsa_pkg.sv
// shared types and constants of the two-level slot allocator
`timescale 1ns / 1ps
package tlsa_pkg;
    localparam int ADDR_W    = 48;
    localparam int SIZE_W    = 21;
    localparam int TOTAL_W   = 17;
    localparam int KIND_W    = 2;
    localparam int COUNT_W   = 7;
    localparam int STAT_W    = 2;
    localparam int USED_W    = 17;
    localparam int CFG_IDX_W = 2;
    localparam int QUOT_W    = 17;

    localparam int MAX_SLOTS_DEF = 65536;
    localparam int REFILL_DEF    = 256;
    localparam int KEEP_DEF      = 256;
    localparam int MAX_BATCH_DEF = 64;

    localparam logic [ADDR_W-1:0]  BASE_RST  = '0;
    localparam logic [SIZE_W-1:0]  SIZE_RST  = 21'd2048;
    localparam logic [TOTAL_W-1:0] TOTAL_RST = 17'd65536;

    localparam logic [CFG_IDX_W-1:0] CFG_BASE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SIZE  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TOTAL = 2'd2;

    typedef enum logic [1:0] {
        K_ALLOC, K_FREE_LOCAL, K_BATCH, K_FREE_GLOBAL
    } t_kind;

    typedef enum logic [1:0] {
        STAT_OK, STAT_EMPTY, STAT_NULL, STAT_REJECT
    } t_status;

    typedef enum logic [3:0] {
        S_IDLE, S_ALLOC, S_REFILL_RD, S_REFILL_WR, S_POP_RD, S_POP_WAIT, S_MUL, S_ADD,
        S_EMIT, S_BATCH, S_DEC, S_DIV, S_CHECK, S_PUSH, S_SPILL_RD, S_SPILL_WR
    } t_state;
endpackage

>>> rtl/core/tlsa_if.sv
// channel interfaces: request, response and configuration write
`timescale 1ns / 1ps
interface slot_req_if import tlsa_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [KIND_W-1:0]  kind;
    logic [ADDR_W-1:0]  address;
    logic [COUNT_W-1:0] count;
    modport source (output valid, kind, address, count, input ready);
    modport sink   (input valid, kind, address, count, output ready);
endinterface

interface slot_rsp_if import tlsa_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [ADDR_W-1:0] slot_address;
    logic [STAT_W-1:0] status;
    logic              last;
    logic [USED_W-1:0] used_slots;
    modport source (output valid, slot_address, status, last, used_slots, input ready);
    modport sink   (input valid, slot_address, status, last, used_slots, output ready);
endinterface

interface slot_cfg_if import tlsa_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [ADDR_W-1:0]    data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

>>> rtl/core/two_level_slot_allocator_top.sv
// two-level slot allocator: global index stack behind one local cache stack
//
// channels: i_req takes one beat per request (kind, address, count); o_rsp gives
// one or more result beats per request, the final one with last set; i_cfg
// writes the base address (0), slot size (1) and slot count (2), which the user
// must do only while idle; the block does not enforce it. writing the slot count
// refills the global stack at once and empties the local one. one request is
// in work at a time. addresses are base + index * slot size. an alloc pops the
// local stack, which is first refilled when empty from the global one with up
// to REFILL_BATCH indices, each read then written. a free stops at a null or
// out-of-range address, else finds the index in the bit-serial divider, one
// quotient bit a cycle, rejects one not below the slot count and pushes the rest;
// a spill moves indices back to the global stack. a batch alloc gives a beat per
// granted slot, then an empty beat if the stacks run out.
// reset: global stack holds 0..N-1, lowest on top, with no clearing pass: slots
// below the lowest stack depth reached since the last fill read their fill value.
// the local stack holds nothing. a stalled receiver holds the result register;
// the next request is accepted while the final beat still waits.
`timescale 1ns / 1ps
module two_level_slot_allocator_top import tlsa_pkg::*; #(
    parameter int MAX_SLOTS    = MAX_SLOTS_DEF,
    parameter int REFILL_BATCH = REFILL_DEF,
    parameter int LOCAL_KEEP   = KEEP_DEF,
    parameter int MAX_BATCH    = MAX_BATCH_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    slot_req_if.sink  i_req,
    slot_rsp_if.source o_rsp,
    slot_cfg_if.sink  i_cfg
);
    localparam int IW     = $clog2(MAX_SLOTS);
    localparam int GCW    = $clog2(MAX_SLOTS + 1);
    localparam int XW     = (GCW > TOTAL_W) ? GCW : TOTAL_W;
    localparam int LDEPTH = LOCAL_KEEP + REFILL_BATCH + 1;
    localparam int LAW    = $clog2(LDEPTH);
    localparam int LCW    = $clog2(LDEPTH + 1);
    localparam int UW     = ((GCW > LCW) ? GCW : LCW) + 1;
    localparam int RCW    = $clog2(REFILL_BATCH + 1);
    localparam int PW     = IW + SIZE_W;
    localparam int DIVW   = SIZE_W + QUOT_W;
    localparam int DCW    = $clog2(QUOT_W);
    localparam int RST_CAP = (MAX_SLOTS < 65536) ? MAX_SLOTS : 65536;

    // stack memories
    logic [IW-1:0] r_gmem [MAX_SLOTS];
    logic [IW-1:0] r_lmem [LDEPTH];
    logic [IW-1:0] r_g_q, r_l_q;
    logic          g_re, g_we, l_re, l_we;
    logic [IW-1:0] g_raddr, g_waddr, g_wdata, l_wdata;
    logic [LAW-1:0] l_raddr, l_waddr;

    t_state r_state, n_state;
    t_kind  r_kind, n_kind;
    logic [ADDR_W-1:0]  r_base, r_addr, n_addr;
    logic [SIZE_W-1:0]  r_size;
    logic [TOTAL_W-1:0] r_total;
    logic [GCW-1:0]     r_gcnt, n_gcnt, r_low, n_low;
    logic [LCW-1:0]     r_lcnt, n_lcnt;
    logic [RCW-1:0]     r_rcnt, n_rcnt;
    logic [COUNT_W-1:0] r_want, n_want, r_n, n_n;
    logic               r_src_g, n_src_g;
    logic [IW-1:0]      r_idx, n_idx;
    logic [PW-1:0]      r_prod, n_prod;
    logic [DIVW-1:0]    r_rem, n_rem, r_dv, n_dv;
    logic [QUOT_W-1:0]  r_q, n_q;
    logic [DCW-1:0]     r_dcnt, n_dcnt;
    logic               r_g_imp;
    logic [IW-1:0]      r_g_impv;
    logic [ADDR_W-1:0]  r_e_addr, n_e_addr;
    t_status            r_e_st, n_e_st;
    logic               r_e_last, n_e_last;
    logic               r_ov, n_ov;
    logic [ADDR_W-1:0]  r_o_addr, n_o_addr;
    logic [STAT_W-1:0]  r_o_st, n_o_st;
    logic               r_o_last, n_o_last;
    logic [USED_W-1:0]  r_o_used, n_o_used;

    logic [GCW-1:0]     cap, new_cap, gtop;
    logic [XW-1:0]      cap_x, new_x;
    logic [UW-1:0]      free_u, cap_u, used_u;
    logic [IW-1:0]      gdata;
    logic [ADDR_W-1:0]  off;
    logic               off_big, ge, out_free, in_acc, cfg_acc;
    logic [COUNT_W-1:0] cnt_cl;
    logic [RCW-1:0]     got;

    // effective slot count, capped at the stack depth
    assign cap_x   = (XW'(r_total) > XW'(MAX_SLOTS)) ? XW'(MAX_SLOTS) : XW'(r_total);
    assign cap     = GCW'(cap_x);
    assign new_x   = (XW'(i_cfg.data[TOTAL_W-1:0]) > XW'(MAX_SLOTS)) ?
                     XW'(MAX_SLOTS) : XW'(i_cfg.data[TOTAL_W-1:0]);
    assign new_cap = GCW'(new_x);
    assign gtop    = r_gcnt - GCW'(1);

    assign free_u = UW'(r_gcnt) + UW'(r_lcnt);
    assign cap_u  = UW'(cap);
    assign used_u = (free_u < cap_u) ? cap_u - free_u : '0;

    // untouched slots below the low-water mark read their fill value
    assign gdata = r_g_imp ? r_g_impv : r_g_q;

    assign off     = r_addr - r_base;
    assign off_big = off >= ADDR_W'({r_size, {QUOT_W{1'b0}}});
    assign ge      = r_rem >= r_dv;
    assign cnt_cl  = (i_req.count > COUNT_W'(MAX_BATCH)) ? COUNT_W'(MAX_BATCH) : i_req.count;
    assign got     = (r_gcnt < GCW'(REFILL_BATCH)) ? RCW'(r_gcnt) : RCW'(REFILL_BATCH);

    assign out_free = !r_ov || o_rsp.ready;
    assign i_req.ready = (r_state == S_IDLE);
    assign i_cfg.ready = 1'b1;
    assign in_acc  = i_req.valid && i_req.ready;
    assign cfg_acc = i_cfg.valid && i_cfg.ready;

    assign o_rsp.valid        = r_ov;
    assign o_rsp.slot_address = r_o_addr;
    assign o_rsp.status       = r_o_st;
    assign o_rsp.last         = r_o_last;
    assign o_rsp.used_slots   = r_o_used;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    priority case (t_kind'(i_req.kind))
                        K_ALLOC: n_state = S_ALLOC;
                        K_BATCH: n_state = S_BATCH;
                        default: n_state = S_DEC;
                    endcase
                end
            end
            S_ALLOC: begin
                if (r_lcnt != '0)      n_state = S_POP_RD;
                else if (r_gcnt != '0) n_state = S_REFILL_RD;
                else                   n_state = S_EMIT;
            end
            S_REFILL_RD: n_state = S_REFILL_WR;
            S_REFILL_WR: n_state = (r_rcnt == RCW'(1)) ? S_ALLOC : S_REFILL_RD;
            S_POP_RD:    n_state = S_POP_WAIT;
            S_POP_WAIT:  n_state = S_MUL;
            S_MUL:       n_state = S_ADD;
            S_ADD:       n_state = S_EMIT;
            S_EMIT: begin
                if (out_free) n_state = r_e_last ? S_IDLE : S_BATCH;
            end
            S_BATCH: begin
                if (r_want == '0)                         n_state = S_EMIT;
                else if (r_n < r_want && r_lcnt != '0)    n_state = S_POP_RD;
                else if (r_n < r_want && r_gcnt != '0)    n_state = S_POP_RD;
                else                                      n_state = S_EMIT;
            end
            S_DEC: begin
                if (r_addr == '0 || r_addr < r_base || off_big) n_state = S_EMIT;
                else                                            n_state = S_DIV;
            end
            S_DIV:   n_state = (r_dcnt == '0) ? S_CHECK : S_DIV;
            S_CHECK: n_state = (XW'(r_q) >= cap_x) ? S_EMIT : S_PUSH;
            S_PUSH: begin
                if (r_kind == K_FREE_LOCAL &&
                    r_lcnt + LCW'(1) > LCW'(LOCAL_KEEP + REFILL_BATCH))
                    n_state = S_SPILL_RD;
                else
                    n_state = S_EMIT;
            end
            S_SPILL_RD: n_state = S_SPILL_WR;
            S_SPILL_WR: n_state = (r_lcnt > LCW'(LOCAL_KEEP)) ? S_SPILL_RD : S_EMIT;
            default:    n_state = S_IDLE;
        endcase
    end

    // datapath and memory strobes
    always_comb begin
        n_kind = r_kind;   n_addr = r_addr;   n_want = r_want;   n_n = r_n;
        n_gcnt = r_gcnt;   n_low = r_low;     n_lcnt = r_lcnt;   n_rcnt = r_rcnt;
        n_src_g = r_src_g; n_idx = r_idx;     n_prod = r_prod;
        n_rem = r_rem;     n_dv = r_dv;       n_q = r_q;         n_dcnt = r_dcnt;
        n_e_addr = r_e_addr; n_e_st = r_e_st; n_e_last = r_e_last;
        n_ov = r_ov && !o_rsp.ready;
        n_o_addr = r_o_addr; n_o_st = r_o_st; n_o_last = r_o_last; n_o_used = r_o_used;
        g_re = 1'b0; g_we = 1'b0; l_re = 1'b0; l_we = 1'b0;
        g_raddr = gtop[IW-1:0];
        g_waddr = r_gcnt[IW-1:0];
        g_wdata = r_idx;
        l_raddr = LAW'(r_lcnt - LCW'(1));
        l_waddr = r_lcnt[LAW-1:0];
        l_wdata = r_idx;
        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_kind = t_kind'(i_req.kind);
                    n_addr = i_req.address;
                    n_want = cnt_cl;
                    n_n    = '0;
                end
            end
            S_ALLOC: begin
                n_src_g = 1'b0;
                n_e_last = 1'b1;
                if (r_lcnt == '0 && r_gcnt != '0) n_rcnt = got;
                n_e_addr = '0;
                n_e_st   = STAT_EMPTY;
            end
            S_REFILL_RD: begin
                g_re   = 1'b1;
                n_gcnt = gtop;
                if (gtop < r_low) n_low = gtop;
            end
            S_REFILL_WR: begin
                l_we    = 1'b1;
                l_wdata = gdata;
                n_lcnt  = r_lcnt + LCW'(1);
                n_rcnt  = r_rcnt - RCW'(1);
            end
            S_POP_RD: begin
                if (r_src_g) begin
                    g_re   = 1'b1;
                    n_gcnt = gtop;
                    if (gtop < r_low) n_low = gtop;
                end else begin
                    l_re   = 1'b1;
                    n_lcnt = r_lcnt - LCW'(1);
                end
            end
            S_POP_WAIT: n_idx = r_src_g ? gdata : r_l_q;
            S_MUL:      n_prod = PW'(r_idx) * PW'(r_size);
            S_ADD: begin
                n_e_addr = r_base + ADDR_W'(r_prod);
                n_e_st   = STAT_OK;
            end
            S_EMIT: begin
                if (out_free) begin
                    n_ov     = 1'b1;
                    n_o_addr = r_e_addr;
                    n_o_st   = r_e_st;
                    n_o_last = r_e_last;
                    n_o_used = USED_W'(used_u);
                end
            end
            S_BATCH: begin
                n_e_addr = '0;
                n_e_last = 1'b1;
                if (r_want == '0) begin
                    n_e_st = STAT_OK;
                end else if (r_n < r_want && (r_lcnt != '0 || r_gcnt != '0)) begin
                    n_src_g  = (r_lcnt == '0);
                    n_e_last = (r_n + COUNT_W'(1) == r_want);
                    n_n      = r_n + COUNT_W'(1);
                end else begin
                    n_e_st = STAT_EMPTY;
                end
            end
            S_DEC: begin
                n_e_addr = '0;
                n_e_last = 1'b1;
                n_e_st   = (r_addr == '0) ? STAT_NULL : STAT_REJECT;
                n_rem    = DIVW'(off);
                n_dv     = DIVW'(r_size) << (QUOT_W - 1);
                n_q      = '0;
                n_dcnt   = DCW'(QUOT_W - 1);
            end
            S_DIV: begin
                // restoring division, one quotient bit a cycle
                n_rem  = ge ? r_rem - r_dv : r_rem;
                n_q    = {r_q[QUOT_W-2:0], ge};
                n_dv   = r_dv >> 1;
                n_dcnt = r_dcnt - DCW'(1);
            end
            S_CHECK: begin
                n_idx  = IW'(r_q);
                n_e_st = (XW'(r_q) >= cap_x) ? STAT_REJECT : STAT_OK;
            end
            S_PUSH: begin
                if (r_kind == K_FREE_GLOBAL) begin
                    if (r_gcnt < GCW'(MAX_SLOTS)) begin
                        g_we   = 1'b1;
                        n_gcnt = r_gcnt + GCW'(1);
                    end
                end else begin
                    l_we   = 1'b1;
                    n_lcnt = r_lcnt + LCW'(1);
                end
            end
            S_SPILL_RD: begin
                l_re   = 1'b1;
                n_lcnt = r_lcnt - LCW'(1);
            end
            S_SPILL_WR: begin
                g_wdata = r_l_q;
                if (r_gcnt < GCW'(MAX_SLOTS)) begin
                    g_we   = 1'b1;
                    n_gcnt = r_gcnt + GCW'(1);
                end
            end
            default: ;
        endcase
        // a write of total_slots refills the global stack by resetting its mark
        if (cfg_acc && i_cfg.index == CFG_TOTAL) begin
            n_gcnt = new_cap;
            n_low  = new_cap;
            n_lcnt = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (g_we) r_gmem[g_waddr] <= g_wdata;
        if (g_re) begin
            r_g_q    <= r_gmem[g_raddr];
            r_g_imp  <= gtop < r_low;
            r_g_impv <= IW'(cap - GCW'(1) - gtop);
        end
        if (l_we) r_lmem[l_waddr] <= l_wdata;
        if (l_re) r_l_q <= r_lmem[l_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ov    <= 1'b0;
            r_base  <= BASE_RST;
            r_size  <= SIZE_RST;
            r_total <= TOTAL_RST;
            r_gcnt  <= GCW'(RST_CAP);
            r_low   <= GCW'(RST_CAP);
            r_lcnt  <= '0;
        end else begin
            r_state <= n_state;
            r_ov    <= n_ov;
            r_gcnt  <= n_gcnt;
            r_low   <= n_low;
            r_lcnt  <= n_lcnt;
            if (cfg_acc) begin
                priority case (i_cfg.index)
                    CFG_BASE:  r_base <= i_cfg.data;
                    CFG_SIZE:  r_size <= (i_cfg.data[SIZE_W-1:0] == '0) ?
                                         SIZE_W'(1) : i_cfg.data[SIZE_W-1:0];
                    CFG_TOTAL: r_total <= i_cfg.data[TOTAL_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_kind <= n_kind;  r_addr <= n_addr;  r_want <= n_want;  r_n <= n_n;
        r_rcnt <= n_rcnt;  r_src_g <= n_src_g; r_idx <= n_idx;   r_prod <= n_prod;
        r_rem <= n_rem;    r_dv <= n_dv;      r_q <= n_q;        r_dcnt <= n_dcnt;
        r_e_addr <= n_e_addr; r_e_st <= n_e_st; r_e_last <= n_e_last;
        r_o_addr <= n_o_addr; r_o_st <= n_o_st; r_o_last <= n_o_last; r_o_used <= n_o_used;
    end

    // local stack never holds more than keep plus refill between requests
    a_lcnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> (r_lcnt <= LCW'(LOCAL_KEEP + REFILL_BATCH)))
        else $error("local stack over its bound");

    // fill mark never rises above the global depth
    a_low_mark: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_low <= r_gcnt)
        else $error("global low-water mark above depth");

    // an accepted request always starts work
    a_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req.valid && i_req.ready) |=> (r_state != S_IDLE))
        else $error("request accepted but not started");
endmodule
